// ===== hdl/cclc_pkg.sv =====
// Shared constants and types for the clock-controlled LFSR cipher core.
package cclc_pkg;

   // Register lengths, in cells.
   localparam int unsigned SHORT_LEN   = 7;
   localparam int unsigned LONG_LEN    = 11;
   localparam int unsigned CONTROL_LEN = 13;

   // The configuration data port is as wide as the widest seed.
   localparam int unsigned CSR_DATA_W = CONTROL_LEN;

   // Seed values after reset.
   localparam logic [SHORT_LEN-1:0]   SEED_SHORT_RESET   = SHORT_LEN'(43);
   localparam logic [LONG_LEN-1:0]    SEED_LONG_RESET    = LONG_LEN'(683);
   localparam logic [CONTROL_LEN-1:0] SEED_CONTROL_RESET = CONTROL_LEN'(6827);

   // Configuration register indexes; the fourth code is unused.
   typedef enum logic [1:0] {
      CSR_SEED_SHORT   = 2'd0,
      CSR_SEED_LONG    = 2'd1,
      CSR_SEED_CONTROL = 2'd2
   } csr_index_type;

   // Seed values as held by the register bank.
   typedef struct packed {
      logic [SHORT_LEN-1:0]   seed_short;
      logic [LONG_LEN-1:0]    seed_long;
      logic [CONTROL_LEN-1:0] seed_control;
   } seeds_type;

   // Control from the handshake logic to the keystream generator.
   typedef struct packed {
      logic step;
      logic reload;
   } keygen_ctl_type;

endpackage

// ===== hdl/cclc_if.sv =====
// Valid/ready channel interfaces for the request and response words.
interface cclc_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic data_bit;

   modport source (output valid, output cmd, output data_bit, input ready);
   modport sink   (input valid, input cmd, input data_bit, output ready);
endinterface

interface cclc_rsp_if;
   logic valid;
   logic ready;
   logic out_bit;

   modport source (output valid, output out_bit, input ready);
   modport sink   (input valid, input out_bit, output ready);
endinterface

// ===== hdl/clock_controlled_lfsr_cipher_core.sv =====
// Top level of the clock-controlled LFSR stream cipher core.
//
//   channel  direction  contents                    handshake
//   req      in         cmd, data_bit               valid/ready
//   rsp      out        out_bit                     valid/ready
//   csr      in         csr_we, csr_index, csr_wdata write enable only
//
// Each request word passes through the input register, where it waits while the
// response register is stalled, and then the response register, so one word can
// be taken in every clock cycle while the receiver keeps taking responses.
// The keystream generator steps once per word, as the word moves from the input
// register to the response register.
// Reset is synchronous and active high; it empties both registers and loads the
// seed reset values into the seeds and the three shift registers.
// While the response register is full and not taken, the input register holds
// its word, and request ready falls only once both registers are full.
module clock_controlled_lfsr_cipher_core (
   input  logic                            clock,
   input  logic                            reset,
   cclc_req_if.sink                        req,
   cclc_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  cclc_pkg::csr_index_type         csr_index,
   input  logic [cclc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cclc_pkg::*;

   // Input register: one word waiting for the keystream.
   logic a_valid_ff, a_valid_in;
   logic a_cmd_ff,   a_cmd_in;
   logic a_data_ff,  a_data_in;

   // Response register.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_bit_ff,   rsp_bit_in;

   logic           req_take;
   logic           advance;
   logic           key_bit;
   seeds_type      seeds;
   keygen_ctl_type keygen_ctl;

   // The word in the input register moves on whenever the response register
   // is empty or is being emptied in this cycle.
   assign advance   = a_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !a_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   assign keygen_ctl.step   = advance;
   assign keygen_ctl.reload = a_cmd_ff;

   cclc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .seeds     (seeds)
   );

   cclc_keygen u_keygen (
      .clock   (clock),
      .reset   (reset),
      .seeds   (seeds),
      .ctl     (keygen_ctl),
      .key_bit (key_bit)
   );

   always_comb begin
      a_valid_in = a_valid_ff;
      a_cmd_in   = a_cmd_ff;
      a_data_in  = a_data_ff;
      if (req_take) begin
         a_valid_in = 1'b1;
         a_cmd_in   = req.cmd;
         a_data_in  = req.data_bit;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_bit_in   = rsp_bit_ff;
      if (advance) begin
         // The same operation encrypts and decrypts.
         rsp_valid_in = 1'b1;
         rsp_bit_in   = a_data_ff ^ key_bit;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_cmd_ff   <= a_cmd_in;
      a_data_ff  <= a_data_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.out_bit = rsp_bit_ff;

`ifndef SYNTHESIS
   // A word leaving the input register always lands in the response register.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp.valid)
      else $error("word left the input register without a response");

   // With both registers full and the response stalled, no word is taken.
   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && rsp_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("request accepted while the pipeline was full");

   // The input register fills only from an accepted request word.
   assert property (@(posedge clock) disable iff (reset)
      (!a_valid_ff && !req_take) |=> !a_valid_ff)
      else $error("input register filled without a request");
`endif

endmodule

// ===== hdl/cclc_csr.sv =====
// Seed register bank written through the configuration port.
module cclc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  cclc_pkg::csr_index_type             csr_index,
   input  logic [cclc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output cclc_pkg::seeds_type                 seeds
);
   import cclc_pkg::*;

   seeds_type seeds_ff;
   seeds_type seeds_in;

   always_comb begin
      seeds_in = seeds_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SEED_SHORT:   seeds_in.seed_short   = csr_wdata[SHORT_LEN-1:0];
            CSR_SEED_LONG:    seeds_in.seed_long    = csr_wdata[LONG_LEN-1:0];
            CSR_SEED_CONTROL: seeds_in.seed_control = csr_wdata[CONTROL_LEN-1:0];
            default:          seeds_in = seeds_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeds_ff.seed_short   <= SEED_SHORT_RESET;
         seeds_ff.seed_long    <= SEED_LONG_RESET;
         seeds_ff.seed_control <= SEED_CONTROL_RESET;
      end else begin
         seeds_ff <= seeds_in;
      end
   end

   assign seeds = seeds_ff;

endmodule

// ===== hdl/cclc_keygen.sv =====
// Three LFSRs with clock control; gives one keystream bit per step.
module cclc_keygen (
   input  logic                     clock,
   input  logic                     reset,
   input  cclc_pkg::seeds_type      seeds,
   input  cclc_pkg::keygen_ctl_type ctl,
   output logic                     key_bit
);
   import cclc_pkg::*;

   logic [SHORT_LEN-1:0]   short_ff,   short_in,   short_cur;
   logic [LONG_LEN-1:0]    long_ff,    long_in,    long_cur;
   logic [CONTROL_LEN-1:0] control_ff, control_in, control_cur;
   logic                   use_short;

   // A reload replaces the running state before the step is taken.
   assign short_cur   = ctl.reload ? seeds.seed_short   : short_ff;
   assign long_cur    = ctl.reload ? seeds.seed_long    : long_ff;
   assign control_cur = ctl.reload ? seeds.seed_control : control_ff;

   assign use_short = control_cur[CONTROL_LEN-1];
   assign key_bit   = use_short ? short_cur[SHORT_LEN-1] : long_cur[LONG_LEN-1];

   always_comb begin
      short_in   = short_ff;
      long_in    = long_ff;
      control_in = control_ff;
      if (ctl.step) begin
         short_in   = short_cur;
         long_in    = long_cur;
         if (use_short) begin
            short_in = {short_cur[SHORT_LEN-2:0], short_cur[0] ^ short_cur[SHORT_LEN-1]};
         end else begin
            long_in = {long_cur[LONG_LEN-2:0], long_cur[0] ^ long_cur[LONG_LEN-1]};
         end
         control_in = {control_cur[CONTROL_LEN-2:0],
                       control_cur[0] ^ control_cur[CONTROL_LEN-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff   <= SEED_SHORT_RESET;
         long_ff    <= SEED_LONG_RESET;
         control_ff <= SEED_CONTROL_RESET;
      end else begin
         short_ff   <= short_in;
         long_ff    <= long_in;
         control_ff <= control_in;
      end
   end

endmodule

// ===== sim/cclc_keystream_checker.sv =====
// Checker that predicts every enciphered bit of the LFSR cipher core and compares responses.
module cclc_keystream_checker (
   input  logic                            clock,
   input  logic                            reset,
   cclc_req_if                             req,
   cclc_rsp_if                             rsp,
   input  logic                            csr_we,
   input  cclc_pkg::csr_index_type         csr_index,
   input  logic [cclc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                     pending,
   output int unsigned                     fail_count,
   output int unsigned                     checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import cclc_pkg::*;

   logic [SHORT_LEN-1:0]   seed_short_q;
   logic [LONG_LEN-1:0]    seed_long_q;
   logic [CONTROL_LEN-1:0] seed_control_q;
   logic [SHORT_LEN-1:0]   short_cells;
   logic [LONG_LEN-1:0]    long_cells;
   logic [CONTROL_LEN-1:0] control_cells;

   // Enciphered bits still owed by the core, oldest first.
   logic expected_out_bits[$];

   // One Fibonacci step: shift towards the top cell, cell 0 takes cell 0 XOR the top cell.
   function automatic logic [63:0] lfsr_advance(input logic [63:0] cells, input int unsigned len);
      logic [63:0] mask;
      logic        feedback;
      mask     = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
      feedback = cells[0] ^ cells[len-1];
      return ((cells << 1) | 64'(feedback)) & mask;
   endfunction

   // Advances the control register and the selected short or long register for one word and returns the enciphered bit.
   function automatic logic encipher_bit(input logic reload_seeds, input logic data_bit);
      logic key;
      if (reload_seeds) begin
         short_cells   = seed_short_q;
         long_cells    = seed_long_q;
         control_cells = seed_control_q;
      end
      if (control_cells[CONTROL_LEN-1]) begin
         key         = short_cells[SHORT_LEN-1];
         short_cells = SHORT_LEN'(lfsr_advance(64'(short_cells), SHORT_LEN));
      end else begin
         key        = long_cells[LONG_LEN-1];
         long_cells = LONG_LEN'(lfsr_advance(64'(long_cells), LONG_LEN));
      end
      control_cells = CONTROL_LEN'(lfsr_advance(64'(control_cells), CONTROL_LEN));
      return data_bit ^ key;
   endfunction

   always @(posedge clock) begin
      logic want;
      if (reset) begin
         seed_short_q   = SEED_SHORT_RESET;
         seed_long_q    = SEED_LONG_RESET;
         seed_control_q = SEED_CONTROL_RESET;
         short_cells    = SEED_SHORT_RESET;
         long_cells     = SEED_LONG_RESET;
         control_cells  = SEED_CONTROL_RESET;
         expected_out_bits.delete();
         fail_count    <= 0;
         checked_count <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_out_bits.size() == 0) begin
               $error("out_bit: expected no word, actual %0b", rsp.out_bit);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_out_bits.pop_front();
               checked_count <= checked_count + 1;
               if (rsp.out_bit !== want) begin
                  $error("out_bit: expected %0b, actual %0b", want, rsp.out_bit);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req.valid && req.ready)
            expected_out_bits.push_back(encipher_bit(req.cmd, req.data_bit));
         // Seed writes only matter at the next reload; the running registers are untouched.
         if (csr_we) begin
            case (csr_index)
               CSR_SEED_SHORT:   seed_short_q   = csr_wdata[SHORT_LEN-1:0];
               CSR_SEED_LONG:    seed_long_q    = csr_wdata[LONG_LEN-1:0];
               CSR_SEED_CONTROL: seed_control_q = csr_wdata[CONTROL_LEN-1:0];
               default: ;
            endcase
         end
      end
      pending <= expected_out_bits.size();
   end

endmodule

// ===== sim/clock_controlled_lfsr_cipher_core_tb.sv =====
// Top of the testbench: clock, reset, stimulus and verdict for the LFSR cipher core.
module clock_controlled_lfsr_cipher_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cclc_pkg::*;

   // Command codes carried in the cmd field of a request word.
   localparam logic CMD_PROCESS = 1'b0;
   localparam logic CMD_RELOAD  = 1'b1;

   // The fourth index is not decoded by the core; writes to it must be ignored.
   localparam csr_index_type CSR_UNUSED = csr_index_type'(2'd3);

   localparam int unsigned RANDOM_SETTINGS   = 8;
   localparam int unsigned WORDS_PER_SETTING = 116;
   localparam int unsigned HOLD_OFF_PHASE    = 2;
   localparam int unsigned PAUSE_PHASE       = 5;
   localparam int unsigned HOLD_OFF_CYCLES   = 48;
   localparam int unsigned SETTLE_CYCLES     = 6;
   localparam int unsigned CYCLE_LIMIT       = 500000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cclc_req_if req_ch ();
   cclc_rsp_if rsp_ch ();

   int unsigned pending;
   int unsigned fail_count;
   int unsigned checked_count;

   // Run statistics for the closing summary, and the hold-off request count that
   // the receiver process serves.
   int unsigned words_sent      = 0;
   int unsigned reloads_sent    = 0;
   int unsigned csr_writes      = 0;
   int unsigned settings_used   = 0;
   int unsigned hold_offs_asked = 0;
   int unsigned cycle_count     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   clock_controlled_lfsr_cipher_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cclc_keystream_checker keystream_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .pending       (pending),
      .fail_count    (fail_count),
      .checked_count (checked_count)
   );

   // Offers one word and returns at the clock edge at which it is accepted. The
   // valid is left high so that a following word goes out without a bubble.
   task automatic send_word(input logic cmd, input logic data_bit);
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= cmd;
      req_ch.data_bit <= data_bit;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      if (cmd == CMD_RELOAD)
         reloads_sent++;
   endtask

   // Leaves the request channel idle for a number of cycles.
   task automatic pause_sender(input int unsigned cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stops sending and waits until every word sent has come back, plus a short
   // settling time, so that the core is idle before any seed is rewritten.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the selected seeds (bit 0 short, bit 1 long, bit 2 control) and,
   // if asked, pokes the unused index with random data as well.
   task automatic load_seeds(input logic [2:0] which, input logic [CSR_DATA_W-1:0] short_word,
                             input logic [CSR_DATA_W-1:0] long_word,
                             input logic [CSR_DATA_W-1:0] control_word,
                             input logic poke_unused);
      if (which[0]) begin
         csr_we <= 1'b1; csr_index <= CSR_SEED_SHORT; csr_wdata <= short_word;
         @(posedge clock);
         csr_writes++;
      end
      if (which[1]) begin
         csr_we <= 1'b1; csr_index <= CSR_SEED_LONG; csr_wdata <= long_word;
         @(posedge clock);
         csr_writes++;
      end
      if (which[2]) begin
         csr_we <= 1'b1; csr_index <= CSR_SEED_CONTROL; csr_wdata <= control_word;
         @(posedge clock);
         csr_writes++;
      end
      if (poke_unused) begin
         csr_we <= 1'b1; csr_index <= CSR_UNUSED; csr_wdata <= CSR_DATA_W'($urandom);
         @(posedge clock);
         csr_writes++;
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // A seed word across the full data port width. The upper bits beyond a
   // register's length must be dropped by the core; the extremes come up often.
   function automatic logic [CSR_DATA_W-1:0] random_seed_word();
      int unsigned pick;
      pick = $urandom_range(0, 5);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return CSR_DATA_W'($urandom_range(0, (1 << CSR_DATA_W) - 1));
   endfunction

   // The receiver runs on its own: it changes between stall patterns at random
   // (always ready, mostly ready, mostly stalled, a fixed rhythm).
   // When the stimulus asks for a hold-off it keeps ready low long enough
   // that both registers of the core fill and request ready drops.
   initial begin : receiver
      int unsigned hold_offs_served;
      int unsigned mode;
      int unsigned mode_left;
      int unsigned tick;
      int unsigned held;
      hold_offs_served = 0;
      mode             = 0;
      mode_left        = 0;
      tick             = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_offs_served != hold_offs_asked) begin
            rsp_ch.ready <= 1'b0;
            held = 0;
            while (held < HOLD_OFF_CYCLES) begin
               @(posedge clock);
               held++;
            end
            hold_offs_served++;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= ((tick % 5) != 4);
            endcase
         end
      end
   end

   // Watchdog: a run that has not finished by the cycle limit is a failure.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned phase_words;
      int unsigned burst_len;
      int unsigned n;
      logic        paused;

      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= CMD_PROCESS;
      req_ch.data_bit <= 1'b0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_SEED_SHORT;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. First the reset seeds, with a reload in the middle of the
      // stream so that it restarts from the reset contents.
      send_word(CMD_PROCESS, 1'b0);
      send_word(CMD_PROCESS, 1'b1);
      send_word(CMD_RELOAD, 1'b0);
      send_word(CMD_PROCESS, 1'b1);
      send_word(CMD_PROCESS, 1'b0);

      // All-zero seeds, plus a write to the unused index. The first two words
      // still run on the old registers, since a seed write alone changes nothing;
      // after the reload every register is stuck at zero and the bit passes straight
      // through.
      drain_results();
      load_seeds(3'b111, '0, '0, '0, 1'b1);
      send_word(CMD_PROCESS, 1'b1);
      send_word(CMD_PROCESS, 1'b0);
      send_word(CMD_RELOAD, 1'b1);
      send_word(CMD_PROCESS, 1'b0);
      send_word(CMD_PROCESS, 1'b1);

      // All ones on the full port width: the short and long seeds must be cut
      // down to their own lengths.
      drain_results();
      load_seeds(3'b111, '1, '1, '1, 1'b0);
      send_word(CMD_RELOAD, 1'b0);
      send_word(CMD_PROCESS, 1'b1);
      send_word(CMD_PROCESS, 1'b0);
      send_word(CMD_PROCESS, 1'b1);
      send_word(CMD_PROCESS, 1'b1);
      send_word(CMD_RELOAD, 1'b1);

      // The control register starts with its top cell set and the short register
      // is all zero, so the first keystream bits come from a stuck register.
      drain_results();
      load_seeds(3'b101, '0, '0, '1, 1'b0);
      send_word(CMD_RELOAD, 1'b1);
      send_word(CMD_PROCESS, 1'b1);
      send_word(CMD_PROCESS, 1'b0);
      send_word(CMD_PROCESS, 1'b1);

      // Random part: each phase takes a fresh seed setting while the core is idle,
      // then mostly starts a new stream with a reload and runs long random bursts,
      // with the odd reload mixed in. Some gaps are skipped so that stretches run
      // without any idling.
      for (phase = 0; phase < RANDOM_SETTINGS; phase++) begin
         drain_results();
         load_seeds(3'($urandom_range(1, 7)), random_seed_word(), random_seed_word(),
                    random_seed_word(), $urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) != 0)
            send_word(CMD_RELOAD, 1'($urandom));
         phase_words = 0;
         paused      = 1'b0;
         if (phase == HOLD_OFF_PHASE) begin
            // Hold the receiver off and keep offering words back to back, so the
            // core fills up and has to refuse further words for a while.
            hold_offs_asked++;
            repeat (32) begin
               send_word(CMD_PROCESS, 1'($urandom));
               phase_words++;
            end
         end
         while (phase_words < WORDS_PER_SETTING) begin
            burst_len = $urandom_range(1, 24);
            for (n = 0; n < burst_len && phase_words < WORDS_PER_SETTING; n++) begin
               send_word(($urandom_range(0, 31) == 0) ? CMD_RELOAD : CMD_PROCESS,
                         1'($urandom));
               phase_words++;
            end
            if (phase == PAUSE_PHASE && !paused && phase_words >= WORDS_PER_SETTING / 2) begin
               // Mid-stream the sender waits until every word has come back.
               drain_results();
               paused = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
               pause_sender($urandom_range(1, 6));
            end
         end
      end

      drain_results();
      $display("Covered %0d words (%0d with reload) over %0d seed settings, %0d responses checked.",
               words_sent, reloads_sent, settings_used, checked_count);
      $display("Made %0d register writes and %0d long receiver hold-off(s) in %0d cycles.",
               csr_writes, hold_offs_asked, cycle_count);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/cclc_pkg.sv
hdl/cclc_if.sv
hdl/cclc_csr.sv
hdl/cclc_keygen.sv
hdl/clock_controlled_lfsr_cipher_core.sv
sim/cclc_keystream_checker.sv
sim/clock_controlled_lfsr_cipher_core_tb.sv
